@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MCTF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MCTF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/mctf_pkg.sv @@
// Types and constants shared by the MIDI clock transport follower modules.
package mctf_pkg;

	// Request codes of an input beat.
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_US     = 2'd1;
	localparam logic [1:0] REQ_TOGGLE = 2'd2;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_OFF    = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CLOCK_EXTERNAL = 2'd0;
	localparam logic [1:0] CFG_BPM            = 2'd1;
	localparam logic [1:0] CFG_PULSE_SHIFT    = 2'd2;
	localparam logic [1:0] CFG_ACTIVE         = 2'd3;
	localparam int CFG_DATA_W = 16;

	// MIDI system bytes.
	localparam logic [7:0] MIDI_SYSEX     = 8'hF0;
	localparam logic [7:0] MIDI_MTC_QF    = 8'hF1;
	localparam logic [7:0] MIDI_SONG_POS  = 8'hF2;
	localparam logic [7:0] MIDI_SONG_SEL  = 8'hF3;
	localparam logic [7:0] MIDI_EOX       = 8'hF7;
	localparam logic [7:0] MIDI_CLOCK     = 8'hF8;
	localparam logic [7:0] MIDI_START     = 8'hFA;
	localparam logic [7:0] MIDI_CONTINUE  = 8'hFB;
	localparam logic [7:0] MIDI_STOP      = 8'hFC;
	localparam logic [2:0] MIDI_ONE_DATA_HI = 3'b110;

	// Fixed block constants.
	localparam int NUM_CHANNELS = 16;
	localparam logic [7:0] PULSES_PER_QUARTER = 8'd24;
	localparam int INTERVAL_W = 25;
	localparam logic [INTERVAL_W-1:0] US_PER_HALF_MINUTE = 25'd30000000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET     = 25'd250000;
	localparam logic [8:0] BPM_RESET = 9'd120;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic       beat_tick;
		logic       restart_beat;
		logic       playing_now;
		logic [3:0] off_channel;
		logic       last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
		logic scan_step;
		logic load_status;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic exec_stop;
		logic scan_last;
		logic out_space;
	} ctl_sts_t;

endpackage

@@ sv/midi_clock_transport_follower.sv @@
// Top level of the MIDI clock transport follower.
//
// Request channel (req_valid, req_ready, req_data): one beat is a received MIDI
// byte, a one-microsecond tick or a local play/pause toggle.
// Response channel (rsp_valid, rsp_ready, rsp_data): every request beat gives
// one status beat with last set; a Stop byte first gives one all-notes-off
// beat per active channel.
// Configuration: cfg_we writes cfg_data into register cfg_index.
// Sequencing: a request is processed in the cycle it is taken, and its status
// is loaded into the response register once that register has space; a Stop
// byte first scans all sixteen channels in turn, also waiting for space.
// A tempo, pulse-shift or mode write that reloads the tick interval starts a
// bit-serial division, and req_ready stays low until it completes.
// Reset leaves the transport stopped at 120 bpm in internal mode with no
// channels active. When the receiver stalls, the response register holds its
// beat, one further request can still be taken, and then req_ready drops.
module midi_clock_transport_follower
	import mctf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Sequencing of request and response beats.
	mctf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Parsing, counters, divider and response register.
	mctf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ sv/mctf_ctrl.sv @@
// Controller state machine: input handshake and result sequencing.
module mctf_ctrl
	import mctf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_OFF    = 2'd1;
	localparam logic [1:0] ST_STATUS = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	// Input is taken only when idle and no tempo division is running.
	assign req_ready = (state_q == ST_IDLE) && !sts.div_busy;

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req_ready) begin
					cmd.exec = 1'b1;
					state_n = sts.exec_stop ? ST_OFF : ST_STATUS;
				end
			end
			ST_OFF: begin
				if (sts.out_space) begin
					cmd.scan_step = 1'b1;
					if (sts.scan_last) begin
						state_n = ST_STATUS;
					end
				end
			end
			ST_STATUS: begin
				if (sts.out_space) begin
					cmd.load_status = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ sv/mctf_dp.sv @@
// Datapath: configuration, transport state, tempo divider and result register.
module mctf_dp
	import mctf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp_data,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts
);

	// Configuration registers.
	logic        clk_ext_q;
	logic [8:0]  bpm_q;
	logic [2:0]  shift_q;
	logic [15:0] active_q;

	// Transport state.
	logic                  running_q;
	logic [7:0]            pulse_q;
	logic [31:0]           elapsed_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [1:0]            skip_q;
	logic                  sysex_q;
	logic                  tick_q;
	logic                  restart_q;
	logic [3:0]            chan_q;

	// Tempo divider.
	logic                  div_busy_q;
	logic [4:0]            div_cnt_q;
	logic [8:0]            div_rem_q;
	logic [8:0]            div_den_q;
	logic [INTERVAL_W-1:0] div_quo_q;
	logic [9:0]            div_trial;
	logic                  div_ge;
	logic [9:0]            div_rem_n;

	// Output register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Item processing results.
	logic        n_run;
	logic [7:0]  n_pulse;
	logic [31:0] n_el;
	logic [1:0]  n_skip;
	logic        n_sysex;
	logic        n_tick;
	logic        n_restart;
	logic        n_stop;
	logic [7:0]  need;

	// Configuration decode.
	logic        div_start;
	logic [8:0]  div_den_v;
	logic        cfg_clear;

	assign sts.div_busy  = div_busy_q;
	assign sts.exec_stop = n_stop;
	assign sts.scan_last = (chan_q == 4'(NUM_CHANNELS - 1));
	assign sts.out_space = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Effect of one input beat on the transport state, tick check included.
	always_comb begin
		n_run = running_q;
		n_pulse = pulse_q;
		n_el = elapsed_q;
		n_skip = skip_q;
		n_sysex = sysex_q;
		n_tick = 1'b0;
		n_restart = 1'b0;
		n_stop = 1'b0;
		need = PULSES_PER_QUARTER >> shift_q;
		case (req_data.req_type)
			REQ_BYTE: begin
				if (sysex_q) begin
					if (req_data.rx_byte == MIDI_EOX) begin
						n_sysex = 1'b0;
					end
				end else if (skip_q != 2'd0) begin
					n_skip = skip_q - 2'd1;
				end else if (req_data.rx_byte >= MIDI_SYSEX) begin
					case (req_data.rx_byte)
						MIDI_SYSEX: n_sysex = 1'b1;
						MIDI_MTC_QF, MIDI_SONG_SEL: n_skip = 2'd1;
						MIDI_SONG_POS: n_skip = 2'd2;
						MIDI_CLOCK: begin
							if (pulse_q != 8'hFF) begin
								n_pulse = pulse_q + 8'd1;
							end
						end
						MIDI_START: begin
							n_pulse = 8'd0;
							n_restart = 1'b1;
							n_run = 1'b1;
						end
						MIDI_CONTINUE: n_run = 1'b1;
						MIDI_STOP: begin
							n_pulse = 8'd0;
							n_run = 1'b0;
							n_el = 32'd0;
							n_stop = 1'b1;
						end
						default: begin
						end
					endcase
				end else begin
					n_skip = (req_data.rx_byte[7:5] == MIDI_ONE_DATA_HI) ? 2'd1 : 2'd2;
				end
			end
			REQ_US: begin
				if (running_q && !clk_ext_q && elapsed_q != 32'hFFFF_FFFF) begin
					n_el = elapsed_q + 32'd1;
				end
			end
			REQ_TOGGLE: begin
				if (running_q) begin
					n_run = 1'b0;
					n_el = 32'd0;
				end else begin
					n_run = 1'b1;
					n_tick = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Beat tick check after the item.
		if (n_run) begin
			if (!clk_ext_q) begin
				if (n_el >= {7'd0, interval_q}) begin
					n_tick = 1'b1;
					n_el = 32'd0;
				end
			end else if (n_pulse >= need) begin
				n_pulse = 8'd0;
				n_tick = 1'b1;
			end
		end
	end

	// Register writes: a changed value may reload the interval or clear counters.
	always_comb begin
		div_start = 1'b0;
		div_den_v = bpm_q;
		cfg_clear = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_EXTERNAL: begin
					if (cfg_data[0] != clk_ext_q) begin
						div_start = !cfg_data[0];
						cfg_clear = cfg_data[0];
					end
				end
				CFG_BPM: begin
					if (cfg_data[8:0] != bpm_q) begin
						div_den_v = cfg_data[8:0];
						div_start = !clk_ext_q;
						cfg_clear = clk_ext_q;
					end
				end
				CFG_PULSE_SHIFT: begin
					if (cfg_data[2:0] != shift_q) begin
						div_start = !clk_ext_q;
						cfg_clear = clk_ext_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// One restoring division step per cycle.
	assign div_trial = {div_rem_q, div_quo_q[INTERVAL_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};
	assign div_rem_n = div_ge ? (div_trial - {1'b0, div_den_q}) : div_trial;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_ext_q <= 1'b0;
			bpm_q <= BPM_RESET;
			shift_q <= 3'd0;
			active_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_EXTERNAL: clk_ext_q <= cfg_data[0];
				CFG_BPM: bpm_q <= cfg_data[8:0];
				CFG_PULSE_SHIFT: shift_q <= cfg_data[2:0];
				CFG_ACTIVE: active_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Tempo divider: tick interval is the half-minute in microseconds over bpm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= 5'd0;
			interval_q <= INTERVAL_RESET;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 5'd0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			if (div_cnt_q == 5'(INTERVAL_W - 1)) begin
				div_busy_q <= 1'b0;
				interval_q <= {div_quo_q[INTERVAL_W-2:0], div_ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_den_q <= (div_den_v == 9'd0) ? 9'd1 : div_den_v;
			div_rem_q <= 9'd0;
			div_quo_q <= US_PER_HALF_MINUTE;
		end else if (div_busy_q) begin
			div_rem_q <= div_rem_n[8:0];
			div_quo_q <= {div_quo_q[INTERVAL_W-2:0], div_ge};
		end
	end

	// Transport state update on an accepted beat or a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pulse_q <= 8'd0;
			elapsed_q <= 32'd0;
			skip_q <= 2'd0;
			sysex_q <= 1'b0;
			tick_q <= 1'b0;
			restart_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				running_q <= n_run;
				pulse_q <= n_pulse;
				elapsed_q <= n_el;
				skip_q <= n_skip;
				sysex_q <= n_sysex;
				tick_q <= n_tick;
				restart_q <= n_restart;
			end
			if (cfg_clear) begin
				pulse_q <= 8'd0;
				elapsed_q <= 32'd0;
			end
		end
	end

	// Channel scan for all-notes-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 4'd0;
		end else if (cmd.scan_step) begin
			chan_q <= sts.scan_last ? 4'd0 : chan_q + 4'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_status || (cmd.scan_step && active_q[chan_q])) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			rsp_q.result_kind <= KIND_STATUS;
			rsp_q.beat_tick <= tick_q;
			rsp_q.restart_beat <= restart_q;
			rsp_q.playing_now <= running_q;
			rsp_q.off_channel <= 4'd0;
			rsp_q.last <= 1'b1;
		end else if (cmd.scan_step && active_q[chan_q]) begin
			rsp_q.result_kind <= KIND_OFF;
			rsp_q.beat_tick <= 1'b0;
			rsp_q.restart_beat <= 1'b0;
			rsp_q.playing_now <= running_q;
			rsp_q.off_channel <= chan_q;
			rsp_q.last <= 1'b0;
		end
	end

endmodule

@@ sv/mctf_checker.sv @@
// Port-level checker for the MIDI clock transport follower, with its bind.
`include "assert_macros.svh"

module mctf_checker
	import mctf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [1:0]            cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  req_valid,
	input logic                  req_ready,
	input req_t                  req_data,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input rsp_t                  rsp_data
);

	// A stalled response beat keeps its contents.
	`MCTF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// All-notes-off beats are never the final beat and carry no tick or restart.
	`MCTF_ASSERT_NOW(a_off_fields, rsp_valid && (rsp_data.result_kind == KIND_OFF),
		!rsp_data.last && !rsp_data.beat_tick && !rsp_data.restart_beat)

	// All-notes-off beats follow a stop, so the transport is halted.
	`MCTF_ASSERT_NOW(a_off_stopped, rsp_valid && (rsp_data.result_kind == KIND_OFF),
		!rsp_data.playing_now)

	// A restart always leaves the transport running.
	`MCTF_ASSERT_NOW(a_restart_runs, rsp_valid && rsp_data.restart_beat,
		rsp_data.playing_now && rsp_data.last)

endmodule

bind midi_clock_transport_follower mctf_checker u_mctf_checker (.*);
